@@ hw/rtl/kntl_pkg.sv @@
// Package for the keyword/number token lexer: token kinds, scan modes,
// the queue entry format and the keyword tables.
// No dependencies; every other file of the block imports it.
package kntl_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int VALUE_W = 64;

   typedef enum logic [4:0] {
      TOK_NUMBER    = 5'd0,
      TOK_PLUS      = 5'd1,
      TOK_MINUS     = 5'd2,
      TOK_STAR      = 5'd3,
      TOK_SLASH     = 5'd4,
      TOK_NAME      = 5'd5,
      TOK_ASSIGN    = 5'd6,
      TOK_SEMICOLON = 5'd7,
      TOK_LPAREN    = 5'd8,
      TOK_RPAREN    = 5'd9,
      TOK_LBRACE    = 5'd10,
      TOK_RBRACE    = 5'd11,
      TOK_COMMA     = 5'd12,
      TOK_IF        = 5'd13,
      TOK_WHILE     = 5'd14,
      TOK_FOR       = 5'd15,
      TOK_END       = 5'd16
   } token_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_NUMBER  = 3'd1,
      MODE_KEYWORD = 3'd2,
      MODE_NAME    = 3'd3,
      MODE_HALTED  = 3'd4
   } scan_mode_type;

   localparam logic [1:0] KW_IF    = 2'd0;
   localparam logic [1:0] KW_WHILE = 2'd1;
   localparam logic [1:0] KW_FOR   = 2'd2;

   // One queue entry holds every token that one byte causes.
   typedef struct packed {
      logic                 two;
      token_kind_type       kind0;
      logic [VALUE_W-1:0]   value0;
      token_kind_type       kind1;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [2:0] kw_len(input logic [1:0] k);
      logic [2:0] len;
      case (k)
         KW_IF:    len = 3'd2;
         KW_WHILE: len = 3'd5;
         KW_FOR:   len = 3'd3;
         default:  len = 3'd2;
      endcase
      return len;
   endfunction

   function automatic token_kind_type kw_kind(input logic [1:0] k);
      token_kind_type kind;
      case (k)
         KW_IF:    kind = TOK_IF;
         KW_WHILE: kind = TOK_WHILE;
         KW_FOR:   kind = TOK_FOR;
         default:  kind = TOK_IF;
      endcase
      return kind;
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
      logic [7:0] c;
      c = 8'h00;
      case (k)
         KW_IF: begin
            case (p)
               3'd0:    c = "i";
               3'd1:    c = "f";
               default: c = 8'h00;
            endcase
         end
         KW_WHILE: begin
            case (p)
               3'd0:    c = "w";
               3'd1:    c = "h";
               3'd2:    c = "i";
               3'd3:    c = "l";
               3'd4:    c = "e";
               default: c = 8'h00;
            endcase
         end
         KW_FOR: begin
            case (p)
               3'd0:    c = "f";
               3'd1:    c = "o";
               3'd2:    c = "r";
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ hw/rtl/kntl_front.sv @@
// Front end of the lexer: accepts text bytes, runs the scanner state
// machine and pushes the tokens of each byte into the queue as one entry.
// Depends on kntl_pkg.
module kntl_front
   import kntl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            text_byte,
   output logic                  push,
   output queue_entry_type       push_entry
);

   typedef struct packed {
      scan_mode_type       mode;
      logic                set_cand;
      logic [1:0]          cand;
      logic [2:0]          pos;
      logic [VALUE_W-1:0]  acc;
      logic                emit;
      token_kind_type      kind;
   } fresh_type;

   scan_mode_type       mode_ff, mode_in;
   logic [1:0]          cand_ff, cand_in;
   logic [2:0]          pos_ff, pos_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {["0":"9"]};
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return b inside {["a":"z"], ["A":"Z"]};
   endfunction

   function automatic logic is_name_char(input logic [7:0] b);
      return is_digit(b) || is_letter(b) || (b == "_");
   endfunction

   // Scan of a byte that starts a new token.
   function automatic fresh_type scan_fresh(input logic [7:0] b);
      fresh_type f;
      f.mode     = MODE_IDLE;
      f.set_cand = 1'b0;
      f.cand     = KW_IF;
      f.pos      = 3'd0;
      f.acc      = '0;
      f.emit     = 1'b0;
      f.kind     = TOK_END;
      if (b == 8'h00) begin
         f.emit = 1'b1;
      end else if (b == " " || b == 8'h0a || b == 8'h0d) begin
         f.emit = 1'b0;
      end else if (is_digit(b)) begin
         f.mode = MODE_NUMBER;
         f.acc  = {{(VALUE_W-8){1'b0}}, b - 8'("0")};
      end else if (is_letter(b)) begin
         f.mode = MODE_NAME;
         if (b == kw_char(KW_IF, 3'd0) || b == kw_char(KW_WHILE, 3'd0) ||
             b == kw_char(KW_FOR, 3'd0)) begin
            f.mode     = MODE_KEYWORD;
            f.set_cand = 1'b1;
            f.pos      = 3'd1;
            if (b == kw_char(KW_IF, 3'd0)) begin
               f.cand = KW_IF;
            end else if (b == kw_char(KW_WHILE, 3'd0)) begin
               f.cand = KW_WHILE;
            end else begin
               f.cand = KW_FOR;
            end
         end
      end else begin
         f.emit = 1'b1;
         case (b)
            "+":     f.kind = TOK_PLUS;
            "-":     f.kind = TOK_MINUS;
            "*":     f.kind = TOK_STAR;
            "/":     f.kind = TOK_SLASH;
            "=":     f.kind = TOK_ASSIGN;
            ";":     f.kind = TOK_SEMICOLON;
            "(":     f.kind = TOK_LPAREN;
            ")":     f.kind = TOK_RPAREN;
            "{":     f.kind = TOK_LBRACE;
            "}":     f.kind = TOK_RBRACE;
            ",":     f.kind = TOK_COMMA;
            default: begin
               f.kind = TOK_END;
               f.mode = MODE_HALTED;
            end
         endcase
      end
      return f;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         cand_ff <= KW_IF;
         pos_ff  <= 3'd0;
         acc_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         cand_ff <= cand_in;
         pos_ff  <= pos_in;
         acc_ff  <= acc_in;
      end
   end

   always_comb begin
      fresh_type       f;
      logic            use_fresh;
      logic            emit0;
      token_kind_type  kind0;
      logic [VALUE_W-1:0] value0;
      logic [1:0]      k;
      logic [2:0]      len;
      logic [2:0]      p;
      logic [2:0]      p_next;

      f         = scan_fresh(text_byte);
      use_fresh = 1'b0;
      emit0     = 1'b0;
      kind0     = TOK_END;
      value0    = '0;
      mode_in   = mode_ff;
      cand_in   = cand_ff;
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      k         = (cand_ff == 2'd3) ? KW_IF : cand_ff;
      len       = kw_len(k);
      p         = (pos_ff < len) ? pos_ff : 3'd0;
      p_next    = p + 3'd1;

      case (mode_ff)
         MODE_HALTED: begin
            emit0 = 1'b1;
            kind0 = TOK_END;
         end
         MODE_NUMBER: begin
            if (is_digit(text_byte)) begin
               // Times ten as two shifted copies; the sum wraps at 64 bits.
               acc_in = {acc_ff[VALUE_W-4:0], 3'b000} + {acc_ff[VALUE_W-2:0], 1'b0}
                      + {{(VALUE_W-8){1'b0}}, text_byte - 8'("0")};
            end else begin
               emit0     = 1'b1;
               kind0     = TOK_NUMBER;
               value0    = acc_ff;
               use_fresh = 1'b1;
            end
         end
         MODE_KEYWORD: begin
            if (p != 3'd0 && kw_char(k, p) == text_byte) begin
               if (p_next == len) begin
                  emit0   = 1'b1;
                  kind0   = kw_kind(k);
                  mode_in = MODE_IDLE;
                  pos_in  = 3'd0;
               end else begin
                  pos_in = p_next;
               end
            end else if (is_name_char(text_byte)) begin
               mode_in = MODE_NAME;
               pos_in  = 3'd0;
            end else begin
               emit0     = 1'b1;
               kind0     = TOK_NAME;
               use_fresh = 1'b1;
            end
         end
         MODE_NAME: begin
            if (!is_name_char(text_byte)) begin
               emit0     = 1'b1;
               kind0     = TOK_NAME;
               use_fresh = 1'b1;
            end
         end
         default: begin
            use_fresh = 1'b1;
         end
      endcase

      if (use_fresh) begin
         mode_in = f.mode;
         pos_in  = f.pos;
         acc_in  = f.acc;
         if (f.set_cand) begin
            cand_in = f.cand;
         end
      end

      push_entry.two    = emit0 && use_fresh && f.emit;
      push_entry.kind1  = f.kind;
      if (emit0) begin
         push_entry.kind0  = kind0;
         push_entry.value0 = value0;
      end else begin
         push_entry.kind0  = f.kind;
         push_entry.value0 = '0;
      end
      push = accept && (emit0 || (use_fresh && f.emit));
   end

endmodule

@@ hw/rtl/kntl_queue.sv @@
// Short queue of token entries between the scanner and the output side.
// Depends on kntl_pkg.
module kntl_queue
   import kntl_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  queue_entry_type   push_entry,
   input  logic              pop,
   output queue_entry_type   head_entry,
   output queue_status_type  status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   queue_entry_type   entries [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign head_entry       = entries[rd_ptr_ff];
   assign status.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

endmodule

@@ hw/rtl/kntl_back.sv @@
// Output side of the lexer: takes entries from the queue and hands out
// their tokens one word at a time through a registered output stage.
// Depends on kntl_pkg.
module kntl_back
   import kntl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  queue_entry_type            head_entry,
   input  queue_status_type           status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [4:0]                 rsp_token_kind,
   output logic signed [VALUE_W-1:0]  rsp_number_value,
   output logic                       rsp_last_of_run
);

   logic                valid_ff, valid_in;
   logic                second_ff, second_in;
   token_kind_type      kind_ff, kind_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                last_ff, last_in;
   logic                load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      load      = status.not_empty && (!valid_ff || !rsp_stall);
      valid_in  = load || (valid_ff && rsp_stall);
      second_in = second_ff;
      pop       = 1'b0;
      kind_in   = head_entry.kind0;
      value_in  = head_entry.value0;
      last_in   = 1'b1;
      // A two-token entry stays at the head until its second word is loaded.
      if (head_entry.two && !second_ff) begin
         last_in = 1'b0;
      end else if (head_entry.two) begin
         kind_in  = head_entry.kind1;
         value_in = '0;
      end
      if (load) begin
         if (head_entry.two && !second_ff) begin
            second_in = 1'b1;
         end else begin
            second_in = 1'b0;
            pop       = 1'b1;
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_token_kind   = kind_ff;
   assign rsp_number_value = $signed(value_ff);
   assign rsp_last_of_run  = last_ff;

endmodule

@@ hw/rtl/keyword_number_token_lexer.sv @@
// Top level of the keyword/number token lexer: scanner front end, token
// queue and output stage. Depends on kntl_pkg, kntl_front, kntl_queue, kntl_back.
//
//   channel | direction | ports                                    | word
//   req     | in        | req_valid, req_stall, req_text_byte      | one source byte
//   rsp     | out       | rsp_valid, rsp_stall, rsp_token_kind,    | one token
//           |           | rsp_number_value, rsp_last_of_run        |
//
// One byte is accepted per cycle while req_stall is low; its tokens enter the queue
// as one entry, and the first is then loaded from the queue head into the output
// register, from which it is taken while rsp_stall is low.
// The output register gives one token per cycle while rsp_stall is low, so a byte
// with two tokens needs two words; the queue of QUEUE_DEPTH entries absorbs this.
// req_stall is high only while the queue is full; rsp_stall holds the output.
// Reset is synchronous; there is no clearing pass.
module keyword_number_token_lexer
   import kntl_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_text_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [4:0]                 rsp_token_kind,
   output logic signed [VALUE_W-1:0]  rsp_number_value,
   output logic                       rsp_last_of_run
);

   queue_status_type  status;
   queue_entry_type   push_entry;
   queue_entry_type   head_entry;
   logic              push;
   logic              pop;
   logic              accept;

   assign req_stall = status.full;
   assign accept    = req_valid && !status.full;

   kntl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_text_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   kntl_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (status)
   );

   kntl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .status           (status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_number_value (rsp_number_value),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

@@ tb/kntl_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the token lexer testbench: a bytewise model of the scanner
// and the queue of tokens it says are due. Depends on kntl_pkg.
package kntl_tb_pkg;
   import kntl_pkg::*;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef logic [7:0] text_q_type[$];

   typedef struct {
      token_kind_type kind;
      logic [63:0]    value;
      logic           last;
   } due_token_type;

   function automatic bit is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit is_name_char(input logic [7:0] b);
      return is_digit(b) || is_letter(b) || b == "_";
   endfunction

   function automatic bit punct_token(input logic [7:0] b, output token_kind_type kind);
      kind = TOK_END;
      case (b)
         "+": kind = TOK_PLUS;
         "-": kind = TOK_MINUS;
         "*": kind = TOK_STAR;
         "/": kind = TOK_SLASH;
         "=": kind = TOK_ASSIGN;
         ";": kind = TOK_SEMICOLON;
         "(": kind = TOK_LPAREN;
         ")": kind = TOK_RPAREN;
         "{": kind = TOK_LBRACE;
         "}": kind = TOK_RBRACE;
         ",": kind = TOK_COMMA;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   class lexer_scoreboard;
      scan_mode_type  mode;
      logic [1:0]     cand;
      logic [2:0]     pos;
      logic [63:0]    acc;
      due_token_type  tokens_due[$];
      due_token_type  byte_tokens[$];
      string          kw_word[3];
      token_kind_type kw_token[3];
      int             bytes_seen;
      int             tokens_checked;
      int             mismatches;

      function new();
         mode = MODE_IDLE;
         cand = KW_IF;
         pos = 3'd0;
         acc = '0;
         kw_word[KW_IF] = "if";
         kw_word[KW_WHILE] = "while";
         kw_word[KW_FOR] = "for";
         kw_token[KW_IF] = TOK_IF;
         kw_token[KW_WHILE] = TOK_WHILE;
         kw_token[KW_FOR] = TOK_FOR;
         bytes_seen = 0;
         tokens_checked = 0;
         mismatches = 0;
      endfunction

      function void fault(string what);
         mismatches++;
         if (mismatches <= 10) begin
            $display("MISMATCH %s", what);
         end
      endfunction

      function void emit(token_kind_type kind, logic [63:0] value);
         due_token_type t;
         t.kind = kind;
         t.value = value;
         t.last = 1'b0;
         byte_tokens.push_back(t);
      endfunction

      // Scans a byte as the first character of a new token.
      function void start_token(logic [7:0] b);
         token_kind_type kind;
         int k;
         mode = MODE_IDLE;
         pos = 3'd0;
         acc = '0;
         if (b == CHAR_NUL) begin
            emit(TOK_END, '0);
         end else if (b == CHAR_SPACE || b == CHAR_LF || b == CHAR_CR) begin
            return;
         end else if (is_digit(b)) begin
            mode = MODE_NUMBER;
            acc = 64'(b - "0");
         end else if (is_letter(b)) begin
            mode = MODE_NAME;
            for (k = 0; k < 3; k++) begin
               if (mode == MODE_NAME && 8'(kw_word[k][0]) == b) begin
                  mode = MODE_KEYWORD;
                  cand = 2'(k);
                  pos = 3'd1;
               end
            end
         end else if (punct_token(b, kind)) begin
            emit(kind, '0);
         end else begin
            mode = MODE_HALTED;
            emit(TOK_END, '0);
         end
      endfunction

      function void note_byte(logic [7:0] b);
         int unsigned k;
         int unsigned p;
         int unsigned len;
         bytes_seen++;
         byte_tokens.delete();
         case (mode)
            MODE_HALTED: emit(TOK_END, '0);
            MODE_NUMBER: begin
               if (is_digit(b)) begin
                  acc = acc * 64'd10 + 64'(b - "0");
               end else begin
                  emit(TOK_NUMBER, acc);
                  start_token(b);
               end
            end
            MODE_KEYWORD: begin
               k = (cand > KW_FOR) ? KW_IF : cand;
               len = kw_word[k].len();
               p = (pos < len) ? pos : 0;
               if (p > 0 && 8'(kw_word[k][p]) == b) begin
                  p++;
                  if (p == len) begin
                     emit(kw_token[k], '0);
                     mode = MODE_IDLE;
                     pos = 3'd0;
                  end else begin
                     pos = 3'(p);
                  end
               end else if (is_name_char(b)) begin
                  mode = MODE_NAME;
                  pos = 3'd0;
               end else begin
                  emit(TOK_NAME, '0);
                  start_token(b);
               end
            end
            MODE_NAME: begin
               if (!is_name_char(b)) begin
                  emit(TOK_NAME, '0);
                  start_token(b);
               end
            end
            default: start_token(b);
         endcase
         if (byte_tokens.size() > 0) begin
            byte_tokens[byte_tokens.size() - 1].last = 1'b1;
         end
         foreach (byte_tokens[i]) begin
            tokens_due.push_back(byte_tokens[i]);
         end
      endfunction

      function void check_token(logic [4:0] kind, logic [63:0] value, logic last);
         due_token_type want;
         if (tokens_due.size() == 0) begin
            fault($sformatf("token kind %0d arrived with none due", kind));
            return;
         end
         want = tokens_due.pop_front();
         tokens_checked++;
         if (kind !== want.kind || value !== want.value || last !== want.last) begin
            fault($sformatf({"token %0d: kind %0d, expected %0d; value %0d, expected %0d;",
                             " last %0b, expected %0b"},
                            tokens_checked, kind, want.kind, $signed(value),
                            $signed(want.value), last, want.last));
         end
      endfunction

      function void finish_check();
         if (tokens_due.size() > 0) begin
            fault($sformatf("%0d tokens never arrived", tokens_due.size()));
         end
      endfunction
   endclass

endpackage

@@ tb/keyword_number_token_lexer_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for keyword_number_token_lexer: builds source text, drives the
// byte channel, drains the token channel. Depends on kntl_pkg and kntl_tb_pkg.
module keyword_number_token_lexer_tb;
   import kntl_pkg::*;
   import kntl_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 30;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_text_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [4:0]         rsp_token_kind;
   logic signed [63:0] rsp_number_value;
   logic               rsp_last_of_run;
   logic               steady = 1'b0;
   int                 cycle_count = 0;

   lexer_scoreboard sb;
   // Follows the generated text so that an underscore is only placed where
   // it continues a name.
   lexer_scoreboard shadow;

   keyword_number_token_lexer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_number_value (rsp_number_value),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d tokens still due.",
                  CYCLE_LIMIT, sb.tokens_due.size());
         $display("keyword_number_token_lexer regression: fail");
         $finish;
      end
   end

   function automatic bit roll_idle();
      return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   function automatic void put(ref text_q_type q, input logic [7:0] b);
      q.push_back(b);
      shadow.note_byte(b);
   endfunction

   function automatic void put_text(ref text_q_type q, input string s);
      for (int i = 0; i < s.len(); i++) begin
         put(q, 8'(s[i]));
      end
   endfunction

   function automatic logic [7:0] random_letter();
      logic [7:0] c;
      c = 8'("a" + $urandom_range(0, 25));
      if ($urandom_range(0, 1) == 1) begin
         c = c - 8'd32;
      end
      return c;
   endfunction

   function automatic logic [7:0] random_name_char();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2 && (shadow.mode == MODE_NAME || shadow.mode == MODE_KEYWORD)) begin
         return "_";
      end
      if (pick < 5) begin
         return 8'("0" + $urandom_range(0, 9));
      end
      return random_letter();
   endfunction

   // Mostly well-formed token text, with adjacent tokens that force a flush.
   function automatic void add_random_text(ref text_q_type q, input int bytes);
      int    stop;
      int    pick;
      int    len;
      string kw;
      string puncts;
      stop = q.size() + bytes;
      puncts = "+-*/=;(){},";
      while (q.size() < stop) begin
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 2))
            0: kw = "if";
            1: kw = "while";
            default: kw = "for";
         endcase
         if (pick < 15) begin
            put_text(q, kw);
         end else if (pick < 25) begin
            put_text(q, kw.substr(0, $urandom_range(0, kw.len() - 2)));
         end else if (pick < 40) begin
            put(q, random_letter());
            len = $urandom_range(0, 5);
            for (int i = 0; i < len; i++) begin
               put(q, random_name_char());
            end
         end else if (pick < 58) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
               put(q, 8'("0" + $urandom_range(0, 9)));
            end
         end else if (pick < 80) begin
            put(q, 8'(puncts[$urandom_range(0, puncts.len() - 1)]));
         end else if (pick < 93) begin
            case ($urandom_range(0, 2))
               0: put(q, CHAR_SPACE);
               1: put(q, CHAR_LF);
               default: put(q, CHAR_CR);
            endcase
         end else if (pick < 97) begin
            put(q, CHAR_NUL);
         end else begin
            put(q, random_name_char());
         end
      end
   endfunction

   task automatic feed_text(input text_q_type text);
      int sent;
      sent = 0;
      while (sent < text.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            sb.note_byte(req_text_byte);
            sent++;
         end
         if (!req_valid || !req_stall) begin
            if (sent < text.size() && !roll_idle()) begin
               req_valid <= 1'b1;
               req_text_byte <= text[sent];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   endtask

   task automatic drain_tokens();
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            sb.check_token(rsp_token_kind, rsp_number_value, rsp_last_of_run);
         end
         rsp_stall <= roll_idle();
      end
   endtask

   initial begin
      text_q_type directed_text;
      text_q_type random_a;
      text_q_type random_b;
      text_q_type random_c;
      text_q_type tail_text;
      sb = new();
      shadow = new();

      // Every operator, all three keywords, a partial keyword turning into a
      // name, a keyword prefix with a tail, and a partial keyword at end of text.
      put_text(directed_text, "while(i_0){for=9;}");
      put(directed_text, CHAR_CR);
      put(directed_text, CHAR_LF);
      put_text(directed_text, "iffy ,*/-+wh");
      put(directed_text, CHAR_NUL);

      add_random_text(random_a, 270);
      add_random_text(random_b, 270);
      add_random_text(random_c, 270);

      // Largest values, then a byte outside the alphabet halts the scanner.
      put_text(tail_text, " 9223372036854775808 18446744073709551615");
      put(tail_text, 8'hFF);
      for (int i = 0; i < 24; i++) begin
         put(tail_text, 8'($urandom_range(0, 255)));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_tokens();
      join_none

      feed_text(directed_text);
      feed_text(random_a);
      steady <= 1'b1;
      feed_text(random_b);
      steady <= 1'b0;
      feed_text(random_c);
      feed_text(tail_text);

      while (sb.tokens_due.size() > 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
      sb.finish_check();

      $display("Scanned %0d source bytes into %0d checked tokens, with %0d mismatches.",
               sb.bytes_seen, sb.tokens_checked, sb.mismatches);
      $display("Text held keywords, names, wrapping numbers, all operators and a halt.");
      if (sb.mismatches == 0) begin
         $display("keyword_number_token_lexer regression: pass");
      end else begin
         $display("keyword_number_token_lexer regression: fail");
      end
      $finish;
   end

endmodule
